### src/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants for the led matrix column scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcs_pkg;

   localparam int MODULES_DEF = 10;
   localparam int COLUMNS_DEF = 5;

   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_REFRESH = 2'd1;
   localparam logic [1:0] MODE_BLANK   = 2'd2;

   localparam logic [7:0] BLANK_BYTE = 8'hFF;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] module_index;
      logic [2:0] column_index;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] shift_byte;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

### src/lmcs_ram.sv
// ----------------------------------------------------------------------------
// lmcs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 50,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/lmcs_seq.sv
// ----------------------------------------------------------------------------
// lmcs_seq
// Sequencer for the column scanner: frame store clearing pass, frame writes,
// refresh scan with its own address stepper, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcs_seq #(
   parameter  int MODULES = lmcs_pkg::MODULES_DEF,
   parameter  int COLUMNS = lmcs_pkg::COLUMNS_DEF,
   localparam int DEPTH   = MODULES * COLUMNS,
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lmcs_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output lmcs_pkg::rsp_type     rsp_data,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output logic [7:0]            ram_wr_data,
   output logic                  ram_rd_en,
   output logic [AW-1:0]         ram_rd_addr,
   input  wire logic [7:0]       ram_rd_data
);

   localparam int MW = (MODULES > 1) ? $clog2(MODULES) : 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_SEL   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [MW-1:0]     cnt_ff, cnt_in;
   logic [2:0]        col_ff, col_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   lmcs_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              in_range;
   logic [2:0]        col_eff;
   logic [AW-1:0]     wr_addr;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign in_range = ({2'b00, req_data.module_index} < 8'(MODULES)) &&
                     ({1'b0, req_data.column_index} < 4'(COLUMNS));
   assign col_eff  = ({1'b0, col_ff} >= 4'(COLUMNS)) ? 3'd0 : col_ff;
   assign wr_addr  = AW'(int'(req_data.module_index) * COLUMNS
                         + int'(req_data.column_index));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      rd_pend_in    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_addr;
      ram_wr_data   = req_data.pixel_byte;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;

      // frame byte read in the previous cycle goes out inverted
      if (rd_pend_ff) begin
         rsp_strobe_in     = 1'b1;
         rsp_in.shift_byte = ~ram_rd_data;
         rsp_in.last       = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 8'h00;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  lmcs_pkg::MODE_WRITE: begin
                     ram_wr_en = in_range;
                  end
                  lmcs_pkg::MODE_REFRESH: begin
                     // start at the last module of the current column
                     addr_in  = AW'((MODULES - 1) * COLUMNS) + AW'(col_eff);
                     cnt_in   = MW'(MODULES - 1);
                     state_in = S_SCAN;
                  end
                  lmcs_pkg::MODE_BLANK: begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.shift_byte = lmcs_pkg::BLANK_BYTE;
                     rsp_in.last       = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            ram_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            addr_in    = addr_ff - AW'(COLUMNS);
            cnt_in     = cnt_ff - MW'(1);
            if (cnt_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_SEL;
         end
         S_SEL: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.shift_byte = 8'hFF ^ (8'd1 << col_eff);
            rsp_in.last       = 1'b1;
            col_in   = ({1'b0, col_eff} == 4'(COLUMNS - 1)) ? 3'd0 : col_eff + 3'd1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         col_ff        <= 3'd0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         col_ff        <= col_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_read_gives_frame_byte: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_strobe_ff && !rsp_ff.last)
      else $error("frame byte read did not produce a result");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_SCAN) || (state_ff == S_DRAIN))
      else $error("pending read outside scan");

   a_sel_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL) |=> rsp_strobe_ff && rsp_ff.last && (state_ff == S_IDLE))
      else $error("column select byte missing");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < 4'(COLUMNS))
      else $error("column counter out of range");

endmodule

`default_nettype wire

### src/led_matrix_column_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_column_scanner
// Column-multiplexed driver for a row of LED matrix modules on a shift chain.
//
//   channel   ports                         direction  accepted when
//   request   start, busy, req_data         in         start && !busy
//   result    rsp_strobe, rsp_data          out        rsp_strobe (one cycle)
//
// After reset the frame store is cleared, one entry a cycle, with busy high.
// A write, blank or unused item is taken without raising busy; a blank result
// shows in the cycle after it is accepted. A refresh keeps busy high through
// its states SCAN, DRAIN and SEL: one frame store read per module through the
// single read port, then the column-select byte.
// Results come in order, one per cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_column_scanner #(
   parameter int MODULES = lmcs_pkg::MODULES_DEF,
   parameter int COLUMNS = lmcs_pkg::COLUMNS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lmcs_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output lmcs_pkg::rsp_type      rsp_data
);

   localparam int DEPTH = MODULES * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   lmcs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lmcs_seq #(
      .MODULES (MODULES),
      .COLUMNS (COLUMNS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the led matrix column scanner. A queue of frame
// writes, refresh ticks, blanks and ignored items feeds a start/busy driver
// with random gaps. A shadow frame store and column counter predict every
// shifted byte, and a monitor compares each strobed result in order.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int SCAN_MODULES = lmcs_pkg::MODULES_DEF;
   localparam int SCAN_COLUMNS = lmcs_pkg::COLUMNS_DEF;
   localparam int HALF_PERIOD  = 6;
   localparam int TAIL_CYCLES  = SCAN_MODULES + 6;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 430;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   lmcs_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_strobe;
   lmcs_pkg::rsp_type rsp_data;

   led_matrix_column_scanner #(
      .MODULES (SCAN_MODULES),
      .COLUMNS (SCAN_COLUMNS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow of the display state
   logic [7:0] frame_shadow [SCAN_MODULES*SCAN_COLUMNS];
   logic [2:0] column_shadow;

   lmcs_pkg::req_type items_to_send [$];
   lmcs_pkg::rsp_type bytes_due [$];
   int                mismatches = 0;

   function automatic lmcs_pkg::req_type make_item(logic [1:0] mode, int mod_idx,
                                                   int col_idx, int pix);
      lmcs_pkg::req_type it;
      it.mode         = mode;
      it.module_index = 6'(mod_idx);
      it.column_index = 3'(col_idx);
      it.pixel_byte   = 8'(pix);
      return it;
   endfunction

   // work out the shifted bytes an accepted item causes
   task automatic predict_scan(input lmcs_pkg::req_type it);
      int                col;
      lmcs_pkg::rsp_type r;
      case (it.mode)
         lmcs_pkg::MODE_WRITE: begin
            if (it.module_index < SCAN_MODULES && it.column_index < SCAN_COLUMNS)
               frame_shadow[it.module_index*SCAN_COLUMNS + it.column_index] = it.pixel_byte;
         end
         lmcs_pkg::MODE_REFRESH: begin
            col = (column_shadow >= SCAN_COLUMNS) ? 0 : int'(column_shadow);
            // last module goes into the chain first
            for (int m = SCAN_MODULES - 1; m >= 0; m--) begin
               r.shift_byte = ~frame_shadow[m*SCAN_COLUMNS + col];
               r.last       = 1'b0;
               bytes_due.push_back(r);
            end
            r.shift_byte = ~(8'd1 << col);
            r.last       = 1'b1;
            bytes_due.push_back(r);
            column_shadow = (col + 1 >= SCAN_COLUMNS) ? 3'd0 : 3'(col + 1);
         end
         lmcs_pkg::MODE_BLANK: begin
            r.shift_byte = lmcs_pkg::BLANK_BYTE;
            r.last       = 1'b1;
            bytes_due.push_back(r);
         end
         default: ;
      endcase
   endtask

   // driver
   int gap_left  = 0;
   int calm_left = 0;

   always @(posedge clock) begin : drive_items
      int roll;
      if (reset) begin
         start         <= 1'b0;
         gap_left      = 0;
         calm_left     = 0;
         column_shadow = 3'd0;
         foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
      end else begin
         if (start && !busy)
            predict_scan(req_data);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (items_to_send.size() != 0) begin
               req_data <= items_to_send.pop_front();
               start    <= 1'b1;
               if (calm_left > 0) begin
                  calm_left--;
                  gap_left = 0;
               end else begin
                  roll = $urandom_range(0, 99);
                  // now and then a stretch of back-to-back items
                  if (roll < 3)
                     calm_left = $urandom_range(15, 50);
                  if (roll < 55)
                     gap_left = 0;
                  else if (roll < 85)
                     gap_left = $urandom_range(1, 3);
                  else if (roll < 97)
                     gap_left = $urandom_range(4, 10);
                  else
                     gap_left = $urandom_range(20, 40);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_bytes
      lmcs_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: shift_byte %h last %b",
                        rsp_data.shift_byte, rsp_data.last);
         end else begin
            want = bytes_due.pop_front();
            if (rsp_data.shift_byte !== want.shift_byte || rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: shift_byte exp %h got %h, last exp %b got %b",
                           want.shift_byte, rsp_data.shift_byte, want.last, rsp_data.last);
            end
         end
      end
   end

   initial begin : stimulus
      int counted;
      int roll;
      int mi;
      int ci;

      // directed: cleared display, extremes, ignored items, column wrap
      items_to_send.push_back(make_item(lmcs_pkg::MODE_REFRESH, 0, 0, 0));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 0, 0, 8'hFF));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, SCAN_MODULES-1,
                                        SCAN_COLUMNS-1, 8'hA5));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, SCAN_MODULES-1, 0, 8'h01));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 0, SCAN_COLUMNS-1, 8'h80));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 3, 1, 8'h5A));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, SCAN_MODULES, 0, 8'h3C));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 63, 7, 8'hFF));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 0, SCAN_COLUMNS, 8'hC3));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 2, 7, 8'h7E));
      items_to_send.push_back(make_item(MODE_UNUSED, 63, 7, 8'hFF));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_BLANK, 0, 0, 0));
      for (int k = 0; k < SCAN_COLUMNS + 1; k++)
         items_to_send.push_back(make_item(lmcs_pkg::MODE_REFRESH, 63, 7, 8'hFF));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, 0, 0, 8'h00));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_BLANK, 63, 7, 8'hFF));
      items_to_send.push_back(make_item(lmcs_pkg::MODE_REFRESH, 0, 0, 0));

      // random: mostly in-range writes and refreshes, some noise
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE,
                                              $urandom_range(0, SCAN_MODULES-1),
                                              $urandom_range(0, SCAN_COLUMNS-1), $urandom));
         end else if (roll < 75) begin
            items_to_send.push_back(make_item(lmcs_pkg::MODE_REFRESH, $urandom_range(0, 63),
                                              $urandom_range(0, 7), $urandom));
         end else if (roll < 85) begin
            items_to_send.push_back(make_item(lmcs_pkg::MODE_BLANK, $urandom_range(0, 63),
                                              $urandom_range(0, 7), $urandom));
         end else if (roll < 93) begin
            mi = $urandom_range(0, 63);
            ci = $urandom_range(0, 7);
            items_to_send.push_back(make_item(lmcs_pkg::MODE_WRITE, mi, ci, $urandom));
         end else begin
            items_to_send.push_back(make_item(MODE_UNUSED, $urandom_range(0, 63),
                                              $urandom_range(0, 7), $urandom));
         end
         counted++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (items_to_send.size() != 0 || start)
         @(posedge clock);
      while (bytes_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && bytes_due.size() == 0)
         $display("led_matrix_column_scanner regression: pass");
      else
         $display("led_matrix_column_scanner regression: fail");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("led_matrix_column_scanner regression: fail");
      $finish;
   end

endmodule
